FILE: rtl/dagl_pkg.sv
`default_nettype none
package dagl_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int MAX_EDGES_DEF = 256;

    localparam int NODE_W  = 6;
    localparam int CMP_W   = NODE_W + 1;
    localparam int REQ_W   = 2;
    localparam int DIST_W  = 8;
    localparam int DVAL_W  = 7;
    localparam int EDGE_W  = 2 * NODE_W;
    localparam int ORDER_W = NODE_W + 1;
    localparam int LEVEL_W = 6;

    localparam logic [REQ_W-1:0] REQ_EDGE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ORDER = 2'd1;
    localparam logic [REQ_W-1:0] REQ_START = 2'd2;

    localparam logic [DVAL_W-1:0] DVAL_MAX = '1;

    // distance one step further, saturated at the top of the field
    function automatic logic [DVAL_W-1:0] dist_inc(input logic [DVAL_W-1:0] d);
        dist_inc = (d == DVAL_MAX) ? DVAL_MAX : d + DVAL_W'(1);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/dag_asap_alap_levels.sv
// Longest-path schedule levels of a data-flow graph.
// Input channel (in_valid/in_ready): one word per request. An edge load or an
// order entry is stored as it is taken; a start word runs the whole computation,
// and in_ready stays low until its last result word has been taken.
// Output channel (out_valid/out_ready): after a start, one word per stored
// order entry, for nodes 0..V-1 in ascending order, last set on the final one.
// A start with an empty order returns nothing. cfg_wr_en writes asap_mode;
// the user must write it only while the block is idle; it is not enforced.
// A start scans the edge store and the order store, initialises the distances,
// then handles each order entry, walking the edge store for nodes that need it,
// and then sends the result words.
// The walk over the edge store per node, through the single read port of the
// edge memory and the read-modify-write of the distance memory, sets the time.
// A stalled receiver holds the result word in the output register; the block
// waits with it. Reset clears edge and order counts and sets asap_mode to 1.
`default_nettype none
module dag_asap_alap_levels #(
    parameter int MAX_NODES = dagl_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = dagl_pkg::MAX_EDGES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [dagl_pkg::REQ_W-1:0]    req_type,
    input  wire logic [dagl_pkg::NODE_W-1:0]   node_a,
    input  wire logic [dagl_pkg::NODE_W-1:0]   node_b,
    input  wire logic                          is_root,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [dagl_pkg::NODE_W-1:0]   node,
    output logic      [dagl_pkg::LEVEL_W-1:0]  level,
    output logic                               reached,
    output logic                               last
);

    import dagl_pkg::*;

    localparam int EA    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW   = $clog2(MAX_EDGES + 1);
    localparam int NA    = $clog2(MAX_NODES);
    localparam int OCW   = $clog2(MAX_NODES + 1);
    localparam int DEPTH = MAX_NODES + 2;
    localparam int DA    = $clog2(DEPTH);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN_E = 4'd1;
    localparam logic [3:0] S_SCAN_O = 4'd2;
    localparam logic [3:0] S_INIT   = 4'd3;
    localparam logic [3:0] S_MORD   = 4'd4;
    localparam logic [3:0] S_MDIST  = 4'd5;
    localparam logic [3:0] S_MSEL   = 4'd6;
    localparam logic [3:0] S_SWR    = 4'd7;
    localparam logic [3:0] S_ECHK   = 4'd8;
    localparam logic [3:0] S_EWR    = 4'd9;
    localparam logic [3:0] S_OSRC   = 4'd10;
    localparam logic [3:0] S_OSRCD  = 4'd11;
    localparam logic [3:0] S_OLD    = 4'd12;
    localparam logic [3:0] S_OSEND  = 4'd13;

    logic [3:0]           state_reg, state_next;
    logic                 asap_mode_reg;
    logic [ECW-1:0]       edge_count_reg, edge_count_next;
    logic [OCW-1:0]       order_count_reg, order_count_next;
    logic [MAX_NODES-1:0] has_out_reg, has_out_next;
    logic [MAX_NODES-1:0] root_reg, root_next;
    logic [ECW-1:0]       e_reg, e_next;
    logic [OCW-1:0]       i_reg, i_next;
    logic [DA-1:0]        n_reg, n_next;
    logic                 scan_vld_reg, scan_vld_next;
    logic [NODE_W-1:0]    u_reg, u_next;
    logic [DVAL_W-1:0]    du_reg, du_next;
    logic [DA-1:0]        tgt_reg, tgt_next;
    logic [DIST_W-1:0]    src_dist_reg, src_dist_next;
    logic                 out_valid_reg, out_valid_next;
    logic [NODE_W-1:0]    out_node_reg, out_node_next;
    logic [LEVEL_W-1:0]   out_level_reg, out_level_next;
    logic                 out_reached_reg, out_reached_next;
    logic                 out_last_reg, out_last_next;

    // memory ports
    logic                 e_we;
    logic [EA-1:0]        e_waddr, e_raddr;
    logic [EDGE_W-1:0]    e_wdata, e_rdata;
    logic                 o_we;
    logic [NA-1:0]        o_waddr, o_raddr;
    logic [ORDER_W-1:0]   o_wdata, o_rdata;
    logic                 d_we;
    logic [DA-1:0]        d_waddr, d_raddr;
    logic [DIST_W-1:0]    d_wdata, d_rdata;

    dagl_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    dagl_ram #(.WIDTH(ORDER_W), .DEPTH(MAX_NODES)) u_order_ram (
        .clk   (clk),
        .we    (o_we),
        .waddr (o_waddr),
        .wdata (o_wdata),
        .raddr (o_raddr),
        .rdata (o_rdata)
    );

    dagl_ram #(.WIDTH(DIST_W), .DEPTH(DEPTH)) u_dist_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    logic              in_fire;
    logic [CMP_W-1:0]  v7;
    logic [DA-1:0]     v_d, src_d, snk_d;
    logic [ECW-1:0]    e_inc;
    logic              e_more;
    logic              last_pos;
    logic [NODE_W-1:0] es, ed, os;
    logic [NODE_W-1:0] ord_u;
    logic              edge_in_range;
    logic              match;
    logic [NODE_W-1:0] match_tgt;
    logic [DVAL_W-1:0] nd;
    logic              better;
    logic [8:0]        diff;
    logic [LEVEL_W-1:0] lvl;
    logic              got;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign node      = out_node_reg;
    assign level     = out_level_reg;
    assign reached   = out_reached_reg;
    assign last      = out_last_reg;

    assign v7    = CMP_W'(order_count_reg);
    assign v_d   = DA'(order_count_reg);
    assign src_d = v_d;
    assign snk_d = v_d + DA'(1);
    assign e_inc = e_reg + ECW'(1);
    assign e_more = (e_inc < edge_count_reg);
    assign last_pos = asap_mode_reg ? (i_reg == order_count_reg - OCW'(1))
                                    : (i_reg == '0);

    assign es    = e_rdata[EDGE_W-1:NODE_W];
    assign ed    = e_rdata[NODE_W-1:0];
    assign os    = o_rdata[NODE_W-1:0];
    assign ord_u = o_rdata[NODE_W-1:0];
    assign edge_in_range = ({1'b0, es} < v7) && ({1'b0, ed} < v7);
    assign match = asap_mode_reg ? ((es == u_reg) && ({1'b0, ed} < v7))
                                 : ((ed == u_reg) && ({1'b0, es} < v7));
    assign match_tgt = asap_mode_reg ? ed : es;

    assign nd     = dist_inc(du_reg);
    assign better = !d_rdata[DIST_W-1] || (nd > d_rdata[DVAL_W-1:0]);

    // level from the distance word of the current node
    assign got  = d_rdata[DIST_W-1] && (asap_mode_reg || src_dist_reg[DIST_W-1]);
    assign diff = asap_mode_reg
                ? ({2'b00, d_rdata[DVAL_W-1:0]} - 9'd1)
                : ({2'b00, src_dist_reg[DVAL_W-1:0]} - {2'b00, d_rdata[DVAL_W-1:0]} - 9'd1);
    always_comb
    begin
        if (!got || diff[8])
        begin
            lvl = '0;
        end
        else if (diff[7:6] != 2'b00)
        begin
            lvl = '1;
        end
        else
        begin
            lvl = diff[LEVEL_W-1:0];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        edge_count_next  = edge_count_reg;
        order_count_next = order_count_reg;
        has_out_next     = has_out_reg;
        root_next        = root_reg;
        e_next           = e_reg;
        i_next           = i_reg;
        n_next           = n_reg;
        scan_vld_next    = 1'b0;
        u_next           = u_reg;
        du_next          = du_reg;
        tgt_next         = tgt_reg;
        src_dist_next    = src_dist_reg;
        out_valid_next   = out_valid_reg;
        out_node_next    = out_node_reg;
        out_level_next   = out_level_reg;
        out_reached_next = out_reached_reg;
        out_last_next    = out_last_reg;

        e_we    = 1'b0;
        e_waddr = edge_count_reg[EA-1:0];
        e_wdata = {node_a, node_b};
        e_raddr = e_reg[EA-1:0];
        o_we    = 1'b0;
        o_waddr = order_count_reg[NA-1:0];
        o_wdata = {is_root, node_a};
        o_raddr = i_reg[NA-1:0];
        d_we    = 1'b0;
        d_waddr = tgt_reg;
        d_wdata = {1'b1, nd};
        d_raddr = n_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (req_type)
                        REQ_EDGE:
                        begin
                            if (({1'b0, node_a} < CMP_W'(MAX_NODES))
                                && ({1'b0, node_b} < CMP_W'(MAX_NODES))
                                && (edge_count_reg < ECW'(MAX_EDGES)))
                            begin
                                e_we            = 1'b1;
                                edge_count_next = edge_count_reg + ECW'(1);
                            end
                        end
                        REQ_ORDER:
                        begin
                            if (({1'b0, node_a} < CMP_W'(MAX_NODES))
                                && (order_count_reg < OCW'(MAX_NODES)))
                            begin
                                o_we             = 1'b1;
                                order_count_next = order_count_reg + OCW'(1);
                            end
                        end
                        REQ_START:
                        begin
                            if (order_count_reg != '0)
                            begin
                                has_out_next = '0;
                                root_next    = '0;
                                e_next       = '0;
                                i_next       = '0;
                                state_next   = S_SCAN_E;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SCAN_E:
            begin
                // read of one edge overlaps the check of the one before
                if (e_reg < edge_count_reg)
                begin
                    e_next        = e_inc;
                    scan_vld_next = 1'b1;
                end
                if (scan_vld_reg && edge_in_range)
                begin
                    has_out_next[es[NA-1:0]] = 1'b1;
                end
                if (!(e_reg < edge_count_reg) && !scan_vld_reg)
                begin
                    state_next = S_SCAN_O;
                end
            end

            S_SCAN_O:
            begin
                if (i_reg < order_count_reg)
                begin
                    i_next        = i_reg + OCW'(1);
                    scan_vld_next = 1'b1;
                end
                if (scan_vld_reg && o_rdata[ORDER_W-1] && ({1'b0, os} < v7))
                begin
                    root_next[os[NA-1:0]] = 1'b1;
                end
                if (!(i_reg < order_count_reg) && !scan_vld_reg)
                begin
                    n_next     = '0;
                    state_next = S_INIT;
                end
            end

            S_INIT:
            begin
                d_we    = 1'b1;
                d_waddr = n_reg;
                if (n_reg < v_d)
                begin
                    d_wdata = (asap_mode_reg ? root_reg[n_reg[NA-1:0]]
                                             : !has_out_reg[n_reg[NA-1:0]])
                            ? {1'b1, DVAL_W'(1)} : '0;
                end
                else if (n_reg == src_d)
                begin
                    d_wdata = asap_mode_reg ? {1'b1, DVAL_W'(0)} : '0;
                end
                else
                begin
                    d_wdata = asap_mode_reg ? '0 : {1'b1, DVAL_W'(0)};
                end
                if (n_reg == snk_d)
                begin
                    i_next     = asap_mode_reg ? '0 : order_count_reg - OCW'(1);
                    state_next = S_MORD;
                end
                else
                begin
                    n_next = n_reg + DA'(1);
                end
            end

            S_MORD:
            begin
                state_next = S_MDIST;
            end

            S_MDIST:
            begin
                u_next  = ord_u;
                d_raddr = DA'({1'b0, ord_u});
                if ({1'b0, ord_u} < v7)
                begin
                    state_next = S_MSEL;
                end
                else
                begin
                    state_next = S_OSRC;
                end
            end

            S_MSEL:
            begin
                du_next = d_rdata[DVAL_W-1:0];
                if (!d_rdata[DIST_W-1])
                begin
                    state_next = S_OSRC;
                end
                else if (asap_mode_reg && !has_out_reg[u_reg[NA-1:0]])
                begin
                    tgt_next   = snk_d;
                    d_raddr    = snk_d;
                    state_next = S_SWR;
                end
                else if (!asap_mode_reg && root_reg[u_reg[NA-1:0]])
                begin
                    tgt_next   = src_d;
                    d_raddr    = src_d;
                    state_next = S_SWR;
                end
                else if (edge_count_reg != '0)
                begin
                    e_next     = '0;
                    e_raddr    = '0;
                    state_next = S_ECHK;
                end
                else
                begin
                    state_next = S_OSRC;
                end
            end

            S_SWR:
            begin
                d_we       = better;
                state_next = S_OSRC;
            end

            S_ECHK:
            begin
                if (match)
                begin
                    tgt_next   = DA'({1'b0, match_tgt});
                    d_raddr    = DA'({1'b0, match_tgt});
                    state_next = S_EWR;
                end
                else if (e_more)
                begin
                    e_next  = e_inc;
                    e_raddr = e_inc[EA-1:0];
                end
                else
                begin
                    state_next = S_OSRC;
                end
            end

            S_EWR:
            begin
                d_we = better;
                if (e_more)
                begin
                    e_next     = e_inc;
                    e_raddr    = e_inc[EA-1:0];
                    state_next = S_ECHK;
                end
                else
                begin
                    state_next = S_OSRC;
                end
            end

            S_OSRC:
            begin
                d_raddr    = src_d;
                state_next = S_OSRCD;
            end

            S_OSRCD:
            begin
                src_dist_next = d_rdata;
                n_next        = '0;
                d_raddr       = '0;
                state_next    = S_OLD;
            end

            S_OLD:
            begin
                out_valid_next   = 1'b1;
                out_node_next    = NODE_W'(n_reg);
                out_level_next   = lvl;
                out_reached_next = got;
                out_last_next    = ((n_reg + DA'(1)) == v_d);
                state_next       = S_OSEND;
            end

            S_OSEND:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        n_next     = n_reg + DA'(1);
                        d_raddr    = n_reg + DA'(1);
                        state_next = S_OLD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // end of one node's walk: step along the order or go report
        if ((state_next == S_OSRC) && (state_reg != S_OSRC)
            && (state_reg != S_IDLE) && !last_pos)
        begin
            i_next     = asap_mode_reg ? i_reg + OCW'(1) : i_reg - OCW'(1);
            state_next = S_MORD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            asap_mode_reg   <= 1'b1;
            edge_count_reg  <= '0;
            order_count_reg <= '0;
            scan_vld_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            edge_count_reg  <= edge_count_next;
            order_count_reg <= order_count_next;
            scan_vld_reg    <= scan_vld_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wr_en)
            begin
                asap_mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        has_out_reg     <= has_out_next;
        root_reg        <= root_next;
        e_reg           <= e_next;
        i_reg           <= i_next;
        n_reg           <= n_next;
        u_reg           <= u_next;
        du_reg          <= du_next;
        tgt_reg         <= tgt_next;
        src_dist_reg    <= src_dist_next;
        out_node_reg    <= out_node_next;
        out_level_reg   <= out_level_next;
        out_reached_reg <= out_reached_next;
        out_last_reg    <= out_last_next;
    end

endmodule
`default_nettype wire

FILE: rtl/dagl_ram.sv
`default_nettype none
module dagl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: tb/dagl_level_check.sv
`timescale 1ns / 100ps
module dagl_level_check (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_wr_data,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [dagl_pkg::REQ_W-1:0]    req_type,
    input  wire logic [dagl_pkg::NODE_W-1:0]   node_a,
    input  wire logic [dagl_pkg::NODE_W-1:0]   node_b,
    input  wire logic                          is_root,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [dagl_pkg::NODE_W-1:0]   node,
    input  wire logic [dagl_pkg::LEVEL_W-1:0]  level,
    input  wire logic                          reached,
    input  wire logic                          last,
    output int                                 fails,
    output int                                 pending
);

    import dagl_pkg::*;

    typedef struct packed {
        logic [NODE_W-1:0]  node;
        logic [LEVEL_W-1:0] level;
        logic               reached;
        logic               last;
    } level_word_t;

    logic [EDGE_W-1:0]  edge_mem  [MAX_EDGES_DEF];
    logic [ORDER_W-1:0] order_mem [MAX_NODES_DEF];
    logic [DIST_W-1:0]  dist_mem  [MAX_NODES_DEF + 2];
    int          edge_cnt  = 0;
    int          order_cnt = 0;
    logic        asap_mode = 1'b1;
    level_word_t level_q [$];

    // longer path into node v, saturated at the top of the distance field
    function automatic void relax(input int from_d, input int v);
        int nd;
        nd = (from_d >= int'(DVAL_MAX)) ? int'(DVAL_MAX) : from_d + 1;
        if (!dist_mem[v][7] || nd > int'(dist_mem[v][6:0]))
            dist_mem[v] = {1'b1, 7'(nd)};
    endfunction

    // longest-path levels of the stored graph, one word per order entry
    function automatic void predict_levels();
        int          v, src, snk, i, e, u, du, s, d, lvl;
        bit          got;
        bit          has_succ [MAX_NODES_DEF];
        bit          root_of  [MAX_NODES_DEF];
        level_word_t w;
        v = order_cnt;
        if (v == 0)
            return;
        src = v;
        snk = v + 1;
        for (i = 0; i < MAX_NODES_DEF + 2; i++)
            dist_mem[i] = '0;
        for (i = 0; i < MAX_NODES_DEF; i++)
        begin
            has_succ[i] = 1'b0;
            root_of[i]  = 1'b0;
        end
        for (e = 0; e < edge_cnt; e++)
        begin
            s = edge_mem[e][11:6];
            d = edge_mem[e][5:0];
            if (s < v && d < v)
                has_succ[s] = 1'b1;
        end
        for (i = 0; i < v; i++)
        begin
            u = order_mem[i][5:0];
            if (u < v && order_mem[i][6])
                root_of[u] = 1'b1;
        end

        if (asap_mode)
        begin
            dist_mem[src] = 8'h80;
            for (i = 0; i < v; i++)
                if (root_of[i])
                    relax(0, i);
            for (i = 0; i < v; i++)
            begin
                u = order_mem[i][5:0];
                if (u >= v || !dist_mem[u][7])
                    continue;
                du = dist_mem[u][6:0];
                if (!has_succ[u])
                begin
                    relax(du, snk);
                    continue;
                end
                for (e = 0; e < edge_cnt; e++)
                begin
                    s = edge_mem[e][11:6];
                    d = edge_mem[e][5:0];
                    if (s == u && d < v)
                        relax(du, d);
                end
            end
        end
        else
        begin
            dist_mem[snk] = 8'h80;
            for (i = 0; i < v; i++)
                if (!has_succ[i])
                    relax(0, i);
            for (i = v - 1; i >= 0; i--)
            begin
                u = order_mem[i][5:0];
                if (u >= v || !dist_mem[u][7])
                    continue;
                du = dist_mem[u][6:0];
                if (root_of[u])
                begin
                    relax(du, src);
                    continue;
                end
                for (e = 0; e < edge_cnt; e++)
                begin
                    s = edge_mem[e][11:6];
                    d = edge_mem[e][5:0];
                    if (d == u && s < v)
                        relax(du, s);
                end
            end
        end

        for (i = 0; i < v; i++)
        begin
            lvl = 0;
            got = 1'b0;
            if (dist_mem[i][7])
            begin
                if (asap_mode)
                begin
                    lvl = int'(dist_mem[i][6:0]) - 1;
                    got = 1'b1;
                end
                else if (dist_mem[src][7])
                begin
                    lvl = int'(dist_mem[src][6:0]) - int'(dist_mem[i][6:0]) - 1;
                    got = 1'b1;
                end
            end
            if (lvl < 0)
                lvl = 0;
            if (lvl > 63)
                lvl = 63;
            w.node    = i[NODE_W-1:0];
            w.level   = lvl[LEVEL_W-1:0];
            w.reached = got;
            w.last    = (i == v - 1);
            level_q   = {level_q, w};
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        level_word_t want;
        if (!rst_n)
        begin
            edge_cnt  = 0;
            order_cnt = 0;
            asap_mode = 1'b1;
            level_q.delete();
            fails     = 0;
            pending   = 0;
        end
        else
        begin
            if (cfg_wr_en)
                asap_mode = cfg_wr_data;

            if (out_valid && out_ready)
            begin
                if (level_q.size() == 0)
                begin
                    if (fails < 10)
                        $display("unexpected word: node %0d lvl %0d rch %0b last %0b",
                                 node, level, reached, last);
                    fails++;
                end
                else
                begin
                    want = level_q.pop_front();
                    if (node !== want.node || level !== want.level ||
                        reached !== want.reached || last !== want.last)
                    begin
                        if (fails < 10)
                            $display({"level mismatch: exp node %0d lvl %0d rch %0b last %0b,",
                                      " got node %0d lvl %0d rch %0b last %0b"},
                                     want.node, want.level, want.reached, want.last,
                                     node, level, reached, last);
                        fails++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                if (req_type == REQ_EDGE)
                begin
                    if (edge_cnt < MAX_EDGES_DEF)
                    begin
                        edge_mem[edge_cnt] = {node_a, node_b};
                        edge_cnt++;
                    end
                end
                else if (req_type == REQ_ORDER)
                begin
                    if (order_cnt < MAX_NODES_DEF)
                    begin
                        order_mem[order_cnt] = {is_root, node_a};
                        order_cnt++;
                    end
                end
                else if (req_type == REQ_START)
                    predict_levels();
            end

            pending = level_q.size();
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
module tb;
    import dagl_pkg::*;

    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;
    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int SETTLE_CYCLES = 600;
    localparam int HOLD_AT       = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int RAND_ROUNDS   = 70;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic               cfg_wr_data = 1'b0;
    logic               in_valid    = 1'b0;
    logic [REQ_W-1:0]   req_type    = REQ_EDGE;
    logic [NODE_W-1:0]  node_a      = '0;
    logic [NODE_W-1:0]  node_b      = '0;
    logic               is_root     = 1'b0;
    logic               out_ready   = 1'b0;
    logic               in_ready;
    logic               out_valid;
    logic [NODE_W-1:0]  node;
    logic [LEVEL_W-1:0] level;
    logic               reached;
    logic               last;

    int fails;
    int pending;
    int cycle_cnt  = 0;
    int taken      = 0;
    int ord_pos    = 0;
    int edge_pos   = 0;
    bit send_burst = 1'b0;

    always #5 clk = ~clk;

    dag_asap_alap_levels u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .node_a      (node_a),
        .node_b      (node_b),
        .is_root     (is_root),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .node        (node),
        .level       (level),
        .reached     (reached),
        .last        (last)
    );

    dagl_level_check u_level_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .node_a      (node_a),
        .node_b      (node_b),
        .is_root     (is_root),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .node        (node),
        .level       (level),
        .reached     (reached),
        .last        (last),
        .fails       (fails),
        .pending     (pending)
    );

    task automatic send_word(input logic [REQ_W-1:0] req, input logic [NODE_W-1:0] a,
                             input logic [NODE_W-1:0] b, input logic root);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        req_type = req;
        node_a   = a;
        node_b   = b;
        is_root  = root;
        do @(posedge clk); while (!in_ready);
        if (req == REQ_ORDER)
            ord_pos++;
        if (req == REQ_EDGE)
            edge_pos++;
    endtask

    // mostly the next node in topological order, sometimes any node
    task automatic send_order();
        logic [NODE_W-1:0] a;
        if (ord_pos < MAX_NODES_DEF && $urandom_range(0, 6) != 0)
            a = ord_pos[NODE_W-1:0];
        else
            a = NODE_W'($urandom_range(0, 63));
        send_word(REQ_ORDER, a, NODE_W'($urandom), $urandom_range(0, 4) == 0);
    endtask

    // mostly forward edges among known nodes, sometimes any pair
    task automatic send_edge();
        int hi, b;
        hi = (ord_pos > 63) ? 63 : ((ord_pos < 1) ? 1 : ord_pos);
        b  = $urandom_range(1, hi);
        if ($urandom_range(0, 6) == 0)
            send_word(REQ_EDGE, NODE_W'($urandom), NODE_W'($urandom), 1'($urandom));
        else
            send_word(REQ_EDGE, NODE_W'($urandom_range(0, b - 1)), NODE_W'(b),
                      1'($urandom));
    endtask

    task automatic drain(input int settle);
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic set_mode(input logic asap);
        drain(SETTLE_CYCLES);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = asap;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random gaps, bursts, and one long hold-off
    initial
    begin
        int gap;
        bit burst;
        bit held;
        burst = 1'b0;
        held  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 32 == 0)
                burst = ($urandom_range(0, 2) == 0);
            gap = burst ? 0 : $urandom_range(0, 7);
            @(negedge clk);
            if (gap != 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
            // hold off once while more words are due and the sender waits
            if (!held && taken >= HOLD_AT && !last && in_valid)
            begin
                held = 1'b1;
                @(negedge clk);
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
        end
    end

    initial
    begin
        int r, n_ord, n_edge;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty order, then an unused request code
        send_word(REQ_START, 6'd63, 6'd0, 1'b1);
        send_word(REQ_NONE, 6'd63, 6'd63, 1'b1);
        // single node with no root: unreached in both modes
        send_word(REQ_ORDER, 6'd0, 6'd63, 1'b0);
        send_word(REQ_START, 6'd0, 6'd0, 1'b0);
        set_mode(1'b0);
        send_word(REQ_START, 6'd21, 6'd42, 1'b1);
        set_mode(1'b1);

        // duplicates, self loop, back edge, endpoints beyond the order
        send_word(REQ_EDGE, 6'd0, 6'd1, 1'b0);
        send_word(REQ_EDGE, 6'd1, 6'd2, 1'b1);
        send_word(REQ_EDGE, 6'd0, 6'd2, 1'b0);
        send_word(REQ_EDGE, 6'd2, 6'd2, 1'b0);
        send_word(REQ_EDGE, 6'd0, 6'd1, 1'b1);
        send_word(REQ_EDGE, 6'd2, 6'd0, 1'b0);
        send_word(REQ_EDGE, 6'd63, 6'd0, 1'b1);
        send_word(REQ_EDGE, 6'd1, 6'd63, 1'b0);
        send_word(REQ_EDGE, 6'd63, 6'd63, 1'b1);
        // repeated node in the order, root set only on a later entry
        send_word(REQ_ORDER, 6'd1, 6'd0, 1'b0);
        send_word(REQ_ORDER, 6'd2, 6'd63, 1'b0);
        send_word(REQ_ORDER, 6'd63, 6'd0, 1'b1);
        send_word(REQ_ORDER, 6'd2, 6'd63, 1'b0);
        send_word(REQ_ORDER, 6'd0, 6'd0, 1'b1);
        send_word(REQ_START, 6'd5, 6'd10, 1'b0);
        set_mode(1'b0);
        send_word(REQ_START, 6'd10, 6'd5, 1'b1);

        // grow the graph a little per round and start after each round
        for (r = 0; r < RAND_ROUNDS; r++)
        begin
            if ($urandom_range(0, 4) == 0)
                set_mode(1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 4) == 0)
                drain(0);
            send_burst = ($urandom_range(0, 3) == 0);
            n_ord  = $urandom_range(1, 2);
            n_edge = $urandom_range(2, 5);
            while (n_ord + n_edge > 0)
            begin
                if ($urandom_range(1, n_ord + n_edge) <= n_ord)
                begin
                    send_order();
                    n_ord--;
                end
                else
                begin
                    send_edge();
                    n_edge--;
                end
            end
            if ($urandom_range(0, 7) == 0)
                send_word(REQ_NONE, NODE_W'($urandom), NODE_W'($urandom), 1'($urandom));
            send_word(REQ_START, NODE_W'($urandom), NODE_W'($urandom), 1'($urandom));
        end

        // overflow both stores, then full-size starts in both modes
        send_burst = 1'b0;
        set_mode(1'b1);
        while (ord_pos < MAX_NODES_DEF + 4)
            send_order();
        while (edge_pos < MAX_EDGES_DEF + 8)
            send_edge();
        send_word(REQ_START, NODE_W'($urandom), NODE_W'($urandom), 1'($urandom));
        set_mode(1'b0);
        send_word(REQ_START, NODE_W'($urandom), NODE_W'($urandom), 1'($urandom));
        set_mode(1'b1);
        send_word(REQ_START, NODE_W'($urandom), NODE_W'($urandom), 1'($urandom));

        drain(SETTLE_CYCLES);
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
